// File: src/kdvf_pkg.sv
`timescale 1ns / 1ps
package kdvf_pkg;

   // default datapath format
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // fixed field formats
   localparam int DT_FRAC   = 16;
   localparam int IO_W      = 32;
   localparam int DT_W      = 16;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 1;
   localparam int STEP_W    = 5;

   localparam logic [CSR_W-1:0] Q_RESET = 24'd32768;
   localparam logic [CSR_W-1:0] R_RESET = 24'd52429;

   // sum term signs and product shift choice
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_SUB  = 1'b1;
   localparam logic SH_DT   = 1'b1;
   localparam logic SH_FRAC = 1'b0;

   typedef enum logic [1:0] {
      MODE_PREDICT = 2'd0,
      MODE_UPDATE  = 2'd1,
      MODE_INIT    = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROC_NOISE = 1'b0,
      CSR_MEAS_NOISE = 1'b1
   } csr_idx_type;

   // operand sources and write-back targets
   typedef enum logic [4:0] {
      SRC_ZERO, SRC_D, SRC_V, SRC_PDD, SRC_PDV, SRC_PVD, SRC_PVV,
      SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_T4, SRC_T5, SRC_T6, SRC_T7,
      SRC_AIN, SRC_ZIN, SRC_VIN, SRC_DT, SRC_Q, SRC_R, SRC_HALF, SRC_QUARTER
   } src_type;

   typedef enum logic [2:0] {
      K_LIN, K_MUL, K_DIV, K_ZCHK, K_END
   } kind_type;

   typedef struct packed {
      kind_type kind;
      src_type  dst;
      src_type  sa;
      src_type  sb;
      src_type  sc;
      logic     nb;
      logic     nc;
      logic     sh_dt;
   } uop_type;

   function automatic uop_type mk_lin(src_type dst, src_type a, logic nb, src_type b,
                                      logic nc, src_type c);
      uop_type u;
      u.kind = K_LIN; u.dst = dst; u.sa = a; u.sb = b; u.sc = c;
      u.nb = nb; u.nc = nc; u.sh_dt = SH_FRAC;
      return u;
   endfunction

   function automatic uop_type mk_mul(src_type dst, src_type a, src_type b, logic sh);
      uop_type u;
      u.kind = K_MUL; u.dst = dst; u.sa = a; u.sb = b; u.sc = SRC_ZERO;
      u.nb = OP_ADD; u.nc = OP_ADD; u.sh_dt = sh;
      return u;
   endfunction

   function automatic uop_type mk_div(src_type dst, src_type a, src_type b);
      uop_type u;
      u.kind = K_DIV; u.dst = dst; u.sa = a; u.sb = b; u.sc = SRC_ZERO;
      u.nb = OP_ADD; u.nc = OP_ADD; u.sh_dt = SH_FRAC;
      return u;
   endfunction

   function automatic uop_type mk_ctl(kind_type k, src_type a);
      uop_type u;
      u.kind = k; u.dst = SRC_ZERO; u.sa = a; u.sb = SRC_ZERO; u.sc = SRC_ZERO;
      u.nb = OP_ADD; u.nc = OP_ADD; u.sh_dt = SH_FRAC;
      return u;
   endfunction

   // microprogram: one operation per step for each mode
   function automatic uop_type uop_fetch(mode_type mode, logic [STEP_W-1:0] step);
      uop_type u;
      u = mk_ctl(K_END, SRC_ZERO);
      case (mode)
         MODE_PREDICT: begin
            case (step)
               5'd0:  u = mk_lin(SRC_T1, SRC_AIN, OP_ADD, SRC_ZERO, OP_ADD, SRC_ZERO);
               5'd1:  u = mk_mul(SRC_T1, SRC_T1, SRC_DT, SH_DT);        // a*dt
               5'd2:  u = mk_mul(SRC_T0, SRC_V, SRC_DT, SH_DT);         // v*dt
               5'd3:  u = mk_mul(SRC_T2, SRC_T1, SRC_DT, SH_DT);
               5'd4:  u = mk_mul(SRC_T2, SRC_T2, SRC_HALF, SH_FRAC);    // 0.5*a*dt^2
               5'd5:  u = mk_mul(SRC_T3, SRC_Q, SRC_DT, SH_DT);
               5'd6:  u = mk_mul(SRC_T3, SRC_T3, SRC_DT, SH_DT);        // q*dt^2
               5'd7:  u = mk_mul(SRC_T4, SRC_T3, SRC_DT, SH_DT);        // q*dt^3
               5'd8:  u = mk_mul(SRC_T5, SRC_T4, SRC_DT, SH_DT);        // q*dt^4
               5'd9:  u = mk_mul(SRC_T5, SRC_T5, SRC_QUARTER, SH_FRAC);
               5'd10: u = mk_mul(SRC_T4, SRC_T4, SRC_HALF, SH_FRAC);
               5'd11: u = mk_mul(SRC_T6, SRC_PVD, SRC_DT, SH_DT);
               5'd12: u = mk_lin(SRC_T6, SRC_PDD, OP_SUB, SRC_T6, OP_ADD, SRC_ZERO);
               5'd13: u = mk_mul(SRC_T7, SRC_PVV, SRC_DT, SH_DT);
               5'd14: u = mk_lin(SRC_D, SRC_D, OP_SUB, SRC_T0, OP_SUB, SRC_T2);
               5'd15: u = mk_lin(SRC_V, SRC_V, OP_ADD, SRC_T1, OP_ADD, SRC_ZERO);
               5'd16: u = mk_lin(SRC_T0, SRC_PDV, OP_SUB, SRC_T7, OP_ADD, SRC_ZERO);
               5'd17: u = mk_mul(SRC_T1, SRC_T0, SRC_DT, SH_DT);
               5'd18: u = mk_lin(SRC_PDD, SRC_T6, OP_SUB, SRC_T1, OP_ADD, SRC_T5);
               5'd19: u = mk_lin(SRC_PDV, SRC_T0, OP_SUB, SRC_T4, OP_ADD, SRC_ZERO);
               5'd20: u = mk_lin(SRC_PVD, SRC_PVD, OP_SUB, SRC_T7, OP_SUB, SRC_T4);
               5'd21: u = mk_lin(SRC_PVV, SRC_PVV, OP_ADD, SRC_T3, OP_ADD, SRC_ZERO);
               default: u = mk_ctl(K_END, SRC_ZERO);
            endcase
         end
         MODE_UPDATE: begin
            case (step)
               5'd0:  u = mk_lin(SRC_T3, SRC_ZIN, OP_ADD, SRC_ZERO, OP_ADD, SRC_ZERO);
               5'd1:  u = mk_lin(SRC_T0, SRC_PDD, OP_ADD, SRC_R, OP_ADD, SRC_ZERO);
               5'd2:  u = mk_ctl(K_ZCHK, SRC_T0);                       // s == 0
               5'd3:  u = mk_div(SRC_T1, SRC_PDD, SRC_T0);              // k0
               5'd4:  u = mk_div(SRC_T2, SRC_PVD, SRC_T0);              // k1
               5'd5:  u = mk_lin(SRC_T3, SRC_T3, OP_SUB, SRC_D, OP_ADD, SRC_ZERO);
               5'd6:  u = mk_mul(SRC_T4, SRC_T1, SRC_T3, SH_FRAC);
               5'd7:  u = mk_lin(SRC_D, SRC_D, OP_ADD, SRC_T4, OP_ADD, SRC_ZERO);
               5'd8:  u = mk_mul(SRC_T4, SRC_T2, SRC_T3, SH_FRAC);
               5'd9:  u = mk_lin(SRC_V, SRC_V, OP_ADD, SRC_T4, OP_ADD, SRC_ZERO);
               5'd10: u = mk_mul(SRC_T4, SRC_T1, SRC_PDD, SH_FRAC);
               5'd11: u = mk_mul(SRC_T5, SRC_T1, SRC_PDV, SH_FRAC);
               5'd12: u = mk_mul(SRC_T6, SRC_T2, SRC_PDD, SH_FRAC);
               5'd13: u = mk_mul(SRC_T7, SRC_T2, SRC_PDV, SH_FRAC);
               5'd14: u = mk_lin(SRC_PDD, SRC_PDD, OP_SUB, SRC_T4, OP_ADD, SRC_ZERO);
               5'd15: u = mk_lin(SRC_PDV, SRC_PDV, OP_SUB, SRC_T5, OP_ADD, SRC_ZERO);
               5'd16: u = mk_lin(SRC_PVD, SRC_PVD, OP_SUB, SRC_T6, OP_ADD, SRC_ZERO);
               5'd17: u = mk_lin(SRC_PVV, SRC_PVV, OP_SUB, SRC_T7, OP_ADD, SRC_ZERO);
               default: u = mk_ctl(K_END, SRC_ZERO);
            endcase
         end
         MODE_INIT: begin
            case (step)
               5'd0:  u = mk_lin(SRC_D, SRC_ZIN, OP_ADD, SRC_ZERO, OP_ADD, SRC_ZERO);
               5'd1:  u = mk_lin(SRC_V, SRC_VIN, OP_ADD, SRC_ZERO, OP_ADD, SRC_ZERO);
               default: u = mk_ctl(K_END, SRC_ZERO);
            endcase
         end
         default: u = mk_ctl(K_END, SRC_ZERO);
      endcase
      return u;
   endfunction

endpackage

// File: src/kalman_distance_velocity_filter_core.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// req       req_valid/req_ready    mode, accel, time step, distance, velocity
// rsp       rsp_valid/rsp_ready    distance/velocity estimates, skip and clip flags
// csr       csr_valid/csr_ready    register index, 24-bit write data
//
// One item at a time through a microprogram on a shared adder, a four-pass
// multiplier and a radix-2 divider. An update with zero innovation variance
// stops at the zero check and is reported as skipped. A new item is accepted
// only in the idle state, after the last result has gone to the result register.
// Synchronous reset restores the state estimate, covariance and noise registers.
// A finished item waits in the result register; the next item is taken meanwhile.
module kalman_distance_velocity_filter_core #(
   parameter int DATA_WIDTH = kdvf_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = kdvf_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic signed [kdvf_pkg::IO_W-1:0]     req_accel_value,
   input  logic [kdvf_pkg::DT_W-1:0]            req_time_step,
   input  logic signed [kdvf_pkg::IO_W-1:0]     req_distance_value,
   input  logic signed [kdvf_pkg::IO_W-1:0]     req_velocity_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [kdvf_pkg::IO_W-1:0]     rsp_distance_est,
   output logic signed [kdvf_pkg::IO_W-1:0]     rsp_velocity_est,
   output logic                                 rsp_update_skipped,
   output logic                                 rsp_saturated,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [kdvf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [kdvf_pkg::CSR_W-1:0]           csr_wdata
);
   import kdvf_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int OPW = (W + 1 > IO_W + 1) ? W + 1 : IO_W + 1;
   localparam int LW  = OPW + 2;
   localparam int H   = (OPW + 1) / 2;
   localparam int PW  = 4 * H;
   localparam int NB  = W + F;
   localparam int XW  = (PW > NB + 1) ? PW : NB + 1;
   localparam int NBC = $clog2(NB + 1);

   localparam logic signed [LW-1:0] MAXV  = {{(LW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [LW-1:0] MINV  = ~MAXV;
   localparam logic signed [LW-1:0] O_MAX = {{(LW-IO_W+1){1'b0}}, {(IO_W-1){1'b1}}};
   localparam logic signed [LW-1:0] O_MIN = ~O_MAX;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_MUL  = 5'b00100,
      S_DIV  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NBC-1:0]    cnt_ff, cnt_in;
   mode_type          mode_ff;
   logic              skip_ff, skip_in, clip_ff, clip_in;

   logic signed [IO_W-1:0] ain_ff, zin_ff, vin_ff;
   logic [DT_W-1:0]        dt_ff;
   logic [CSR_W-1:0]       q_ff, r_ff;

   logic signed [W-1:0] d_ff, v_ff, pdd_ff, pdv_ff, pvd_ff, pvv_ff;
   logic signed [W-1:0] t0_ff, t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff, t7_ff;

   // multiplier and divider registers
   logic [2*H-1:0] ma_ff, mb_ff;
   logic [PW-1:0]  acc_ff, acc_in;
   logic           neg_ff;
   logic [NB-1:0]  dvd_ff, quo_ff;
   logic [W:0]     rem_ff, rem_in;
   logic [W-1:0]   dm_ff;

   logic signed [IO_W-1:0] rsp_d_ff, rsp_v_ff;
   logic                   rsp_valid_ff, rsp_skip_ff, rsp_clip_ff;

   uop_type uop;
   logic signed [OPW-1:0] opa, opb, opc;
   logic [OPW-1:0]        mag_a, mag_b;
   logic signed [LW-1:0]  lsum;
   logic signed [W-1:0]   lin_res, fin_val;
   logic                  lin_clip, fin_clip;
   logic [H-1:0]          pa, pb;
   logic [2*H-1:0]        prod;
   logic [PW-1:0]         rnd;
   logic [W:0]            r2;
   logic                  ge, up;
   logic [XW-1:0]         fin_mag, lim, mres, sres;
   logic                  wb_en;
   logic signed [W-1:0]   wb_val;
   logic                  mul_go, div_go, accept;
   logic signed [LW-1:0]  dext, vext;
   logic signed [IO_W-1:0] d_out, v_out;
   logic                  d_oclip, v_oclip;

   // operand fetch
   function automatic logic signed [OPW-1:0] opnd(input src_type s);
      logic signed [OPW-1:0] r;
      case (s)
         SRC_D:       r = OPW'(d_ff);
         SRC_V:       r = OPW'(v_ff);
         SRC_PDD:     r = OPW'(pdd_ff);
         SRC_PDV:     r = OPW'(pdv_ff);
         SRC_PVD:     r = OPW'(pvd_ff);
         SRC_PVV:     r = OPW'(pvv_ff);
         SRC_T0:      r = OPW'(t0_ff);
         SRC_T1:      r = OPW'(t1_ff);
         SRC_T2:      r = OPW'(t2_ff);
         SRC_T3:      r = OPW'(t3_ff);
         SRC_T4:      r = OPW'(t4_ff);
         SRC_T5:      r = OPW'(t5_ff);
         SRC_T6:      r = OPW'(t6_ff);
         SRC_T7:      r = OPW'(t7_ff);
         SRC_AIN:     r = OPW'(ain_ff);
         SRC_ZIN:     r = OPW'(zin_ff);
         SRC_VIN:     r = OPW'(vin_ff);
         SRC_DT:      r = $signed(OPW'(dt_ff));
         SRC_Q:       r = $signed(OPW'(q_ff));
         SRC_R:       r = $signed(OPW'(r_ff));
         SRC_HALF:    r = $signed(OPW'(1) << (F - 1));
         SRC_QUARTER: r = $signed(OPW'(1) << (F - 2));
         default:     r = '0;
      endcase
      return r;
   endfunction

   assign uop    = uop_fetch(mode_ff, step_ff);
   assign accept = req_valid && req_ready;

   // operands follow both the selectors and the selected registers
   always_comb begin
      opa = opnd(uop.sa);
      opb = opnd(uop.sb);
      opc = opnd(uop.sc);
   end

   // three-term sum with one saturation
   always_comb begin
      lsum = LW'(opa) + (uop.nb ? -LW'(opb) : LW'(opb)) + (uop.nc ? -LW'(opc) : LW'(opc));
      lin_clip = (lsum > MAXV) || (lsum < MINV);
      if (lsum > MAXV) begin
         lin_res = MAXV[W-1:0];
      end else if (lsum < MINV) begin
         lin_res = MINV[W-1:0];
      end else begin
         lin_res = lsum[W-1:0];
      end
   end

   // operand magnitudes
   assign mag_a = opa[OPW-1] ? -opa : opa;
   assign mag_b = opb[OPW-1] ? -opb : opb;

   // multiplier pass: one HxH partial product per cycle
   assign pa     = cnt_ff[1] ? ma_ff[2*H-1:H] : ma_ff[H-1:0];
   assign pb     = cnt_ff[0] ? mb_ff[2*H-1:H] : mb_ff[H-1:0];
   assign prod   = pa * pb;
   assign acc_in = acc_ff + ((PW'(prod) << (H * 32'(cnt_ff[0]))) << (H * 32'(cnt_ff[1])));
   assign rnd    = uop.sh_dt ? (acc_ff + (PW'(1) << (DT_FRAC - 1))) >> DT_FRAC
                             : (acc_ff + (PW'(1) << (F - 1))) >> F;

   // divider step: restoring, one quotient bit per cycle
   assign r2     = {rem_ff[W-1:0], dvd_ff[NB-1]};
   assign ge     = r2 >= {1'b0, dm_ff};
   assign rem_in = ge ? r2 - {1'b0, dm_ff} : r2;
   assign up     = {rem_ff, 1'b0} >= {2'b00, dm_ff};

   // shared rounding result saturation
   always_comb begin
      fin_mag  = (state_ff == S_MUL) ? XW'(rnd) : XW'(XW'(quo_ff) + XW'(up));
      lim      = (XW'(1) << (W - 1)) - XW'(!neg_ff);
      fin_clip = fin_mag > lim;
      mres     = fin_clip ? lim : fin_mag;
      sres     = neg_ff ? -mres : mres;
      fin_val  = sres[W-1:0];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      skip_in  = skip_ff;
      clip_in  = clip_ff;
      wb_en    = 1'b0;
      wb_val   = lin_res;
      mul_go   = 1'b0;
      div_go   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
               step_in  = '0;
               skip_in  = 1'b0;
               clip_in  = 1'b0;
            end
         end
         S_EXEC: begin
            case (uop.kind)
               K_LIN: begin
                  wb_en   = 1'b1;
                  clip_in = clip_ff | lin_clip;
                  step_in = step_ff + 1'b1;
               end
               K_MUL: begin
                  mul_go   = 1'b1;
                  cnt_in   = '0;
                  state_in = S_MUL;
               end
               K_DIV: begin
                  div_go   = 1'b1;
                  cnt_in   = '0;
                  state_in = S_DIV;
               end
               K_ZCHK: begin
                  if (opa == '0) begin
                     skip_in  = 1'b1;
                     state_in = S_OUT;
                  end else begin
                     step_in = step_ff + 1'b1;
                  end
               end
               default: state_in = S_OUT;
            endcase
         end
         S_MUL: begin
            if (cnt_ff == NBC'(4)) begin
               wb_en    = 1'b1;
               wb_val   = fin_val;
               clip_in  = clip_ff | fin_clip;
               step_in  = step_ff + 1'b1;
               state_in = S_EXEC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DIV: begin
            if (cnt_ff == NBC'(NB)) begin
               wb_en    = 1'b1;
               wb_val   = fin_val;
               clip_in  = clip_ff | fin_clip;
               step_in  = step_ff + 1'b1;
               state_in = S_EXEC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         cnt_ff   <= '0;
         skip_ff  <= 1'b0;
         clip_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
         skip_ff  <= skip_in;
         clip_ff  <= clip_in;
      end
   end

   // input item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= mode_type'(req_mode);
         ain_ff  <= req_accel_value;
         dt_ff   <= req_time_step;
         zin_ff  <= req_distance_value;
         vin_ff  <= req_velocity_value;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= Q_RESET;
         r_ff <= R_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_PROC_NOISE: q_ff <= csr_wdata;
            CSR_MEAS_NOISE: r_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // arithmetic unit registers
   always_ff @(posedge clock) begin
      if (mul_go) begin
         ma_ff  <= (2*H)'(mag_a);
         mb_ff  <= (2*H)'(mag_b);
         acc_ff <= '0;
      end else if (state_ff == S_MUL) begin
         acc_ff <= acc_in;
      end
      if (mul_go || div_go) begin
         neg_ff <= opa[OPW-1] ^ opb[OPW-1];
      end
      if (div_go) begin
         dvd_ff <= {mag_a[W-1:0], {F{1'b0}}};
         dm_ff  <= mag_b[W-1:0];
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (state_ff == S_DIV && cnt_ff != NBC'(NB)) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[NB-2:0], ge};
      end
   end

   // state estimate, covariance and scratch write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff   <= '0;
         v_ff   <= '0;
         pdd_ff <= W'(1) << F;
         pdv_ff <= '0;
         pvd_ff <= '0;
         pvv_ff <= W'(1) << F;
      end else if (wb_en) begin
         case (uop.dst)
            SRC_D:   d_ff   <= wb_val;
            SRC_V:   v_ff   <= wb_val;
            SRC_PDD: pdd_ff <= wb_val;
            SRC_PDV: pdv_ff <= wb_val;
            SRC_PVD: pvd_ff <= wb_val;
            SRC_PVV: pvv_ff <= wb_val;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wb_en) begin
         case (uop.dst)
            SRC_T0:  t0_ff <= wb_val;
            SRC_T1:  t1_ff <= wb_val;
            SRC_T2:  t2_ff <= wb_val;
            SRC_T3:  t3_ff <= wb_val;
            SRC_T4:  t4_ff <= wb_val;
            SRC_T5:  t5_ff <= wb_val;
            SRC_T6:  t6_ff <= wb_val;
            SRC_T7:  t7_ff <= wb_val;
            default: ;
         endcase
      end
   end

   // clip estimates to the 32-bit result range
   always_comb begin
      dext    = LW'(d_ff);
      vext    = LW'(v_ff);
      d_oclip = (dext > O_MAX) || (dext < O_MIN);
      v_oclip = (vext > O_MAX) || (vext < O_MIN);
      d_out   = (dext > O_MAX) ? O_MAX[IO_W-1:0] :
                (dext < O_MIN) ? O_MIN[IO_W-1:0] : dext[IO_W-1:0];
      v_out   = (vext > O_MAX) ? O_MAX[IO_W-1:0] :
                (vext < O_MIN) ? O_MIN[IO_W-1:0] : vext[IO_W-1:0];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_d_ff    <= d_out;
         rsp_v_ff    <= v_out;
         rsp_skip_ff <= skip_ff;
         rsp_clip_ff <= clip_ff | d_oclip | v_oclip;
      end
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distance_est   = rsp_d_ff;
   assign rsp_velocity_est   = rsp_v_ff;
   assign rsp_update_skipped = rsp_skip_ff;
   assign rsp_saturated      = rsp_clip_ff;

endmodule

// File: tb/tb_kalman_distance_velocity_filter_core.sv
`timescale 1ns / 1ps
module tb_kalman_distance_velocity_filter_core;
   import kdvf_pkg::*;

   localparam longint MAXV = 64'sd2147483647;
   localparam longint MINV = -64'sd2147483648;
   localparam longint ONE_Q = 64'sd65536;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam logic [CSR_W-1:0] Q_MAX = 24'hFFFFFF;

   typedef struct {
      mode_type mode;
      logic signed [31:0] accel;
      logic [15:0] dt;
      logic signed [31:0] distance;
      logic signed [31:0] vel;
   } meas_item_type;

   typedef struct {
      logic signed [31:0] distance;
      logic signed [31:0] vel;
      logic skipped;
      logic clipped;
   } estimate_type;

   logic clock;
   logic reset;
   logic req_valid, req_ready;
   logic [1:0] req_mode;
   logic signed [31:0] req_accel_value, req_distance_value, req_velocity_value;
   logic [15:0] req_time_step;
   logic rsp_valid, rsp_ready;
   logic signed [31:0] rsp_distance_est, rsp_velocity_est;
   logic rsp_update_skipped, rsp_saturated;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   kalman_distance_velocity_filter_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_accel_value(req_accel_value), .req_time_step(req_time_step),
      .req_distance_value(req_distance_value), .req_velocity_value(req_velocity_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_distance_est(rsp_distance_est), .rsp_velocity_est(rsp_velocity_est),
      .rsp_update_skipped(rsp_update_skipped), .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // filter state mirror
   longint est_d, est_v, p_dd, p_dv, p_vd, p_vv;
   longint noise_q, noise_r;
   bit clip_seen;

   estimate_type pending_est[$];
   int err_cnt;
   longint cycle_cnt;
   bit idle_on;
   bit hold_req;
   int hold_len;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // limit on run length
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic longint clamp_w(longint x);
      if (x > MAXV) begin
         clip_seen = 1'b1;
         return MAXV;
      end
      if (x < MINV) begin
         clip_seen = 1'b1;
         return MINV;
      end
      return x;
   endfunction

   function automatic longint sat_mag(bit neg, logic [127:0] m);
      logic [127:0] lim;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (m > lim) begin
         clip_seen = 1'b1;
         m = lim;
      end
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   function automatic logic [63:0] mag(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
   endfunction

   // rounded fixed-point product, ties away from zero
   function automatic longint fx_mul(longint a, longint b, int sh);
      logic [127:0] p;
      p = {64'd0, mag(a)} * {64'd0, mag(b)};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      return sat_mag((a < 0) != (b < 0), p);
   endfunction

   // rounded fixed-point quotient, den nonzero
   function automatic longint fx_div(longint num, longint den);
      logic [127:0] n, dm, qt, r;
      n = {64'd0, mag(num)} << 16;
      dm = {64'd0, mag(den)};
      qt = n / dm;
      r = n % dm;
      if (r >= dm - r) qt = qt + 1;
      return sat_mag((num < 0) != (den < 0), qt);
   endfunction

   function automatic void filter_predict(longint a, longint dt);
      longint vdt, adt, hadt2, qdt2, qdt3, qdt4, hq3, qq4, fp00, fp01, fp10, fp11;
      vdt = fx_mul(est_v, dt, 16);
      adt = fx_mul(a, dt, 16);
      hadt2 = fx_mul(fx_mul(adt, dt, 16), ONE_Q / 2, 16);
      qdt2 = fx_mul(fx_mul(noise_q, dt, 16), dt, 16);
      qdt3 = fx_mul(qdt2, dt, 16);
      qdt4 = fx_mul(qdt3, dt, 16);
      hq3 = fx_mul(qdt3, ONE_Q / 2, 16);
      qq4 = fx_mul(qdt4, ONE_Q / 4, 16);
      fp00 = clamp_w(p_dd - fx_mul(p_vd, dt, 16));
      fp01 = clamp_w(p_dv - fx_mul(p_vv, dt, 16));
      fp10 = p_vd;
      fp11 = p_vv;
      est_d = clamp_w(est_d - vdt - hadt2);
      est_v = clamp_w(est_v + adt);
      p_dd = clamp_w(fp00 - fx_mul(fp01, dt, 16) + qq4);
      p_dv = clamp_w(fp01 - hq3);
      p_vd = clamp_w(fp10 - fx_mul(fp11, dt, 16) - hq3);
      p_vv = clamp_w(fp11 + qdt2);
   endfunction

   // returns 1 when innovation variance is zero
   function automatic bit filter_update(longint z);
      longint s, k0, k1, y, o00, o01, o10, o11;
      s = clamp_w(p_dd + noise_r);
      if (s == 0) return 1'b1;
      k0 = fx_div(p_dd, s);
      k1 = fx_div(p_vd, s);
      y = clamp_w(z - est_d);
      est_d = clamp_w(est_d + fx_mul(k0, y, 16));
      est_v = clamp_w(est_v + fx_mul(k1, y, 16));
      o00 = p_dd; o01 = p_dv; o10 = p_vd; o11 = p_vv;
      p_dd = clamp_w(o00 - fx_mul(k0, o00, 16));
      p_dv = clamp_w(o01 - fx_mul(k0, o01, 16));
      p_vd = clamp_w(o10 - fx_mul(k1, o00, 16));
      p_vv = clamp_w(o11 - fx_mul(k1, o01, 16));
      return 1'b0;
   endfunction

   function automatic estimate_type filter_step(meas_item_type it);
      estimate_type e;
      bit skip;
      skip = 1'b0;
      clip_seen = 1'b0;
      case (it.mode)
         MODE_PREDICT: filter_predict(longint'(it.accel), longint'({1'b0, it.dt}));
         MODE_UPDATE:  skip = filter_update(longint'(it.distance));
         MODE_INIT: begin
            est_d = longint'(it.distance);
            est_v = longint'(it.vel);
         end
         default: ;
      endcase
      e.distance = est_d[31:0];
      e.vel = est_v[31:0];
      e.skipped = skip;
      e.clipped = clip_seen;
      return e;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      err_cnt++;
   endtask

   // result checker
   always @(posedge clock) begin
      estimate_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_est.size() == 0) begin
            report_mismatch("unexpected item", 64'sd0, 64'sd0);
         end else begin
            e = pending_est.pop_front();
            if (rsp_distance_est !== e.distance)
               report_mismatch("distance_est", longint'(rsp_distance_est),
                               longint'(e.distance));
            if (rsp_velocity_est !== e.vel)
               report_mismatch("velocity_est", longint'(rsp_velocity_est),
                               longint'(e.vel));
            if (rsp_update_skipped !== e.skipped)
               report_mismatch("update_skipped", longint'(rsp_update_skipped),
                               longint'(e.skipped));
            if (rsp_saturated !== e.clipped)
               report_mismatch("saturated", longint'(rsp_saturated),
                               longint'(e.clipped));
         end
      end
   end

   // result receiver: random stalls, optional long hold-off
   initial begin
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (hold_len) @(posedge clock);
            hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // send one item; valid stays up until accepted
   task automatic send_item(meas_item_type it);
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_accel_value <= it.accel;
      req_time_step <= it.dt;
      req_distance_value <= it.distance;
      req_velocity_value <= it.vel;
      do @(posedge clock); while (!req_ready);
      pending_est.push_back(filter_step(it));
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_fields(mode_type m, logic [31:0] a, logic [15:0] dt,
                              logic [31:0] d, logic [31:0] v);
      meas_item_type it;
      it.mode = m; it.accel = a; it.dt = dt; it.distance = d; it.vel = v;
      send_item(it);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_est.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_csr(csr_idx_type idx, logic [CSR_W-1:0] val);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_PROC_NOISE) noise_q = longint'(val);
      else noise_r = longint'(val);
   endtask

   function automatic meas_item_type rand_item(bit tame);
      meas_item_type it;
      int pick;
      pick = $urandom_range(0, 99);
      it.accel = $urandom;
      it.dt = 16'($urandom);
      it.distance = $urandom;
      it.vel = $urandom;
      if (tame) begin
         it.mode = pick < 55 ? MODE_PREDICT : pick < 92 ? MODE_UPDATE : MODE_INIT;
         it.accel = $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
         it.dt = 16'($urandom_range(0, 13107));
         it.distance = $signed($urandom_range(0, 200 * 65536)) - 20 * 65536;
         it.vel = $signed($urandom_range(0, 40 * 65536)) - 20 * 65536;
      end else begin
         it.mode = mode_type'($urandom_range(0, 3));
      end
      return it;
   endfunction

   task automatic test_directed();
      send_fields(MODE_PREDICT, 32'd65536, 16'd6554, 32'd0, 32'd0);
      send_fields(MODE_INIT, 32'd0, 16'd0, 32'h7FFFFFFF, 32'h80000000);
      send_fields(MODE_PREDICT, 32'h7FFFFFFF, 16'hFFFF, 32'd0, 32'd0);
      send_fields(MODE_PREDICT, 32'h80000000, 16'hFFFF, 32'd0, 32'd0);
      send_fields(MODE_UPDATE, 32'd0, 16'd0, 32'h80000000, 32'd0);
      send_fields(MODE_UPDATE, 32'd0, 16'd0, 32'h7FFFFFFF, 32'd0);
      send_fields(MODE_INIT, 32'd0, 16'd0, 32'd655360, 32'hFFFE0000);
      send_fields(MODE_PREDICT, 32'd0, 16'd0, 32'd0, 32'd0);
      send_fields(MODE_NONE, 32'h7FFFFFFF, 16'hFFFF, 32'h12345678, 32'h9ABCDEF0);
      send_fields(MODE_UPDATE, 32'd0, 16'd0, 32'd600000, 32'd0);
      send_fields(MODE_PREDICT, 32'hFFFF0000, 16'd3277, 32'd0, 32'd0);
      // zero measurement noise: the first update collapses cov_dd, later updates are skipped
      write_csr(CSR_MEAS_NOISE, 24'd0);
      send_fields(MODE_UPDATE, 32'd0, 16'd0, 32'd700000, 32'd0);
      send_fields(MODE_UPDATE, 32'd0, 16'd0, 32'd100000, 32'd0);
      send_fields(MODE_UPDATE, 32'd0, 16'd0, 32'h80000000, 32'd0);
      write_csr(CSR_MEAS_NOISE, R_RESET);
      send_fields(MODE_UPDATE, 32'd0, 16'd0, 32'd0, 32'd0);
   endtask

   task automatic test_noise_extremes();
      write_csr(CSR_PROC_NOISE, Q_MAX);
      write_csr(CSR_MEAS_NOISE, Q_MAX);
      send_fields(MODE_PREDICT, 32'd65536, 16'hFFFF, 32'd0, 32'd0);
      send_fields(MODE_UPDATE, 32'd0, 16'd0, 32'd3000000, 32'd0);
      write_csr(CSR_PROC_NOISE, 24'd0);
      write_csr(CSR_MEAS_NOISE, 24'd1);
      send_fields(MODE_PREDICT, 32'd65536, 16'd32768, 32'd0, 32'd0);
      send_fields(MODE_UPDATE, 32'd0, 16'd0, 32'd65536, 32'd0);
   endtask

   // runs of well-formed tracking with random content, plus some noise items unless tame_only
   task automatic test_tracking(int n, bit tame_only);
      for (int i = 0; i < n; i++)
         send_item(rand_item(tame_only || $urandom_range(0, 9) != 0));
   endtask

   task automatic test_backpressure();
      drain_results();
      hold_len = 400;
      hold_req = 1'b1;
      for (int i = 0; i < 6; i++) send_item(rand_item(1'b1));
   endtask

   initial begin
      logic [CSR_W-1:0] cfg_q[4];
      logic [CSR_W-1:0] cfg_r[4];
      cfg_q = '{24'd0, 24'd32768, 24'd655360, 24'hFFFFFF};
      cfg_r = '{24'd1, 24'd52429, 24'd1310720, 24'hFFFFFF};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= MODE_PREDICT;
      req_accel_value <= '0;
      req_time_step <= '0;
      req_distance_value <= '0;
      req_velocity_value <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_PROC_NOISE;
      csr_wdata <= '0;
      cycle_cnt = 0;
      err_cnt = 0;
      idle_on = 1'b1;
      hold_req = 1'b0;
      hold_len = 0;
      est_d = 0; est_v = 0;
      p_dd = ONE_Q; p_dv = 0; p_vd = 0; p_vv = ONE_Q;
      noise_q = longint'(Q_RESET);
      noise_r = longint'(R_RESET);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_noise_extremes();
      test_backpressure();
      for (int ph = 0; ph < 4; ph++) begin
         write_csr(CSR_PROC_NOISE, cfg_q[ph]);
         write_csr(CSR_MEAS_NOISE, cfg_r[(ph + 1) % 4]);
         test_tracking(300, 1'b0);
      end
      test_backpressure();
      // last part with no idling on either side
      idle_on = 1'b0;
      test_tracking(220, 1'b0);

      req_valid <= 1'b0;
      while (pending_est.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (err_cnt == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/kdvf_pkg.sv
src/kalman_distance_velocity_filter_core.sv
tb/tb_kalman_distance_velocity_filter_core.sv
